FILE: design/write_buffer_erase_coalescer_top_assert.svh
// assertion macros for the write buffer erase coalescer
`ifndef WRITE_BUFFER_ERASE_COALESCER_TOP_ASSERT_SVH
`define WRITE_BUFFER_ERASE_COALESCER_TOP_ASSERT_SVH

// clocked on i_clk, off while i_rst_n is low
`define WBEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same with a separate message for handshake rules
`define WBEC_ASSERT_HS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("handshake rule broken");

`endif

FILE: design/wbec_pkg.sv
// shared types and constants of the write buffer erase coalescer
`default_nettype none

package wbec_pkg;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_LOOKUP = 3'd1;
    localparam logic [2:0] KIND_DUMP   = 3'd2;
    localparam logic [2:0] KIND_APPEND = 3'd3;
    localparam logic [2:0] KIND_SETW   = 3'd4;

    localparam int MAX_RESULTS = 16;
    localparam logic [7:0] MERGE_RESET = 8'd10;

    localparam logic [1:0] OUT_STATUS = 2'd0;
    localparam logic [1:0] OUT_LOOKUP = 2'd1;
    localparam logic [1:0] OUT_DUMP   = 2'd2;

    typedef struct packed {
        logic        is_erase;
        logic [7:0]  start_addr;
        logic [7:0]  end_addr;
        logic [31:0] data;
    } t_entry;

    typedef struct packed {
        logic       latch;
        logic       scan_step;
        logic       clr_idx;
        logic       set_ovf;
        logic       commit_step;
        logic       commit_cnt;
        logic       word_step;
        logic       set_word;
        logic       lookup_rd;
        logic       append;
        logic       idx_inc;
        logic       load_out;
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic total_over;
        logic commit_done;
        logic words_done;
        logic dump_empty;
        logic dump_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/wbec_ctrl.sv
// controller state machine of the write buffer erase coalescer
`default_nettype none

module wbec_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [2:0]       i_kind,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire wbec_pkg::t_sts   i_sts,
    output wbec_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_COMMIT  = 4'd2;
    localparam logic [3:0] ST_WORDS   = 4'd3;
    localparam logic [3:0] ST_FIN     = 4'd4;
    localparam logic [3:0] ST_LOOK    = 4'd5;
    localparam logic [3:0] ST_LOOKOUT = 4'd6;
    localparam logic [3:0] ST_APPEND  = 4'd7;
    localparam logic [3:0] ST_SETW    = 4'd8;
    localparam logic [3:0] ST_DUMP    = 4'd9;
    localparam logic [3:0] ST_DWAIT   = 4'd10;
    localparam logic [3:0] ST_WAIT    = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_WAIT) || (r_state == ST_DWAIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_kind)
                        wbec_pkg::KIND_INSERT: n_state = ST_SCAN;
                        wbec_pkg::KIND_LOOKUP: n_state = ST_LOOK;
                        wbec_pkg::KIND_DUMP:   n_state = ST_DUMP;
                        wbec_pkg::KIND_APPEND: n_state = ST_APPEND;
                        wbec_pkg::KIND_SETW:   n_state = ST_SETW;
                        default:               n_state = ST_FIN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.clr_idx = 1'b1;
                    if (i_sts.total_over) begin
                        o_cmd.set_ovf = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                if (i_sts.commit_done) begin
                    o_cmd.commit_cnt = 1'b1;
                    n_state = ST_WORDS;
                end else begin
                    o_cmd.commit_step = 1'b1;
                end
            end
            ST_WORDS: begin
                if (i_sts.words_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.word_step = 1'b1;
                end
            end
            ST_FIN: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_sel  = wbec_pkg::OUT_STATUS;
                n_state = ST_WAIT;
            end
            ST_LOOK: begin
                o_cmd.lookup_rd = 1'b1;
                n_state = ST_LOOKOUT;
            end
            ST_LOOKOUT: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_sel  = wbec_pkg::OUT_LOOKUP;
                n_state = ST_WAIT;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = ST_FIN;
            end
            ST_SETW: begin
                o_cmd.set_word = 1'b1;
                n_state = ST_FIN;
            end
            ST_DUMP: begin
                if (i_sts.dump_empty) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = wbec_pkg::OUT_DUMP;
                    n_state = ST_DWAIT;
                end
            end
            ST_DWAIT: begin
                if (i_out_ready) begin
                    if (i_sts.dump_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = ST_DUMP;
                    end
                end
            end
            ST_WAIT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: design/wbec_dp.sv
// datapath: command list, word memory, merge logic and result register
`default_nettype none

module wbec_dp #(
    parameter int ADDRESS_COUNT = 128,
    parameter int BUFFER_DEPTH  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_max_merge_span_we,
    input  wire logic [7:0]       i_max_merge_span,
    input  wire logic             i_is_erase,
    input  wire logic [7:0]       i_start_addr,
    input  wire logic [7:0]       i_end_addr,
    input  wire logic [31:0]      i_write_data,
    input  wire logic [6:0]       i_address,
    input  wire wbec_pkg::t_cmd   i_cmd,
    output wbec_pkg::t_sts        o_sts,
    output logic                  o_hit,
    output logic [31:0]           o_read_data,
    output logic                  o_entry_valid,
    output logic                  o_entry_is_erase,
    output logic [7:0]            o_entry_start,
    output logic [7:0]            o_entry_end,
    output logic [31:0]           o_entry_data,
    output logic [4:0]            o_entry_count,
    output logic                  o_overflow,
    output logic                  o_last
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int AW = $clog2(ADDRESS_COUNT);

    logic [7:0]            r_span;
    logic                  r_is_erase;
    logic [7:0]            r_s;
    logic [7:0]            r_en;
    logic [7:0]            r_ns;
    logic [7:0]            r_nend;
    logic [31:0]           r_data;
    logic [6:0]            r_addr;
    logic [7:0]            r_wi;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_nk;
    logic [CW-1:0]         r_np;
    logic                  r_ovf;
    wbec_pkg::t_entry      r_list [BUFFER_DEPTH];
    wbec_pkg::t_entry      r_tmp  [BUFFER_DEPTH];
    wbec_pkg::t_entry      r_pgm  [BUFFER_DEPTH];
    logic [31:0]           r_mem  [ADDRESS_COUNT];
    logic [ADDRESS_COUNT-1:0] r_present;
    logic [31:0]           r_rdata;
    logic                  r_rhit;

    wbec_pkg::t_entry e;
    wbec_pkg::t_entry new_e;
    wbec_pkg::t_entry commit_e;
    logic             contained;
    logic             disjoint;
    logic             too_wide;
    logic [7:0]       us;
    logic [7:0]       ue;
    logic [8:0]       diff;
    logic [CW:0]      total;
    logic [CW-1:0]    pidx;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             set_ok;
    int               dump_n;

    assign e         = r_list[r_idx[IW-1:0]];
    assign new_e     = '{is_erase: r_is_erase, start_addr: r_ns, end_addr: r_nend, data: r_data};
    assign contained = (r_s <= e.start_addr) && (e.end_addr <= r_en);
    assign disjoint  = (e.end_addr < r_ns) || (e.start_addr > r_nend);
    assign us        = (e.start_addr < r_ns) ? e.start_addr : r_ns;
    assign ue        = (e.end_addr > r_nend) ? e.end_addr : r_nend;
    assign diff      = {1'b0, ue} - {1'b0, us};
    assign too_wide  = diff[8] || (diff[7:0] > r_span);
    assign total     = {1'b0, r_nk} + {1'b0, r_np} + (CW+1)'(1);
    assign pidx      = r_idx - r_nk - CW'(1);
    assign set_ok    = int'(r_addr) < ADDRESS_COUNT;
    assign dump_n    = (int'(r_cnt) < wbec_pkg::MAX_RESULTS) ? int'(r_cnt)
                                                             : wbec_pkg::MAX_RESULTS;

    always_comb begin
        if (r_idx < r_nk) begin
            commit_e = r_tmp[r_idx[IW-1:0]];
        end else if (r_idx == r_nk) begin
            commit_e = new_e;
        end else begin
            commit_e = r_pgm[pidx[IW-1:0]];
        end
    end

    assign o_sts.scan_done   = (r_idx == r_cnt);
    assign o_sts.total_over  = total > (CW+1)'(BUFFER_DEPTH);
    assign o_sts.commit_done = ({1'b0, r_idx} == total);
    assign o_sts.words_done  = (r_wi >= r_en) || (int'(r_wi) >= ADDRESS_COUNT);
    assign o_sts.dump_empty  = (r_cnt == '0);
    assign o_sts.dump_last   = (int'(r_idx) + 1 == dump_n);

    // config register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= wbec_pkg::MERGE_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_max_merge_span_we) begin
                r_span <= i_max_merge_span;
            end
            if (i_cmd.commit_cnt) begin
                r_cnt <= total[CW-1:0];
            end else if (i_cmd.append && (r_cnt < CW'(BUFFER_DEPTH))) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_erase <= i_is_erase;
            r_s        <= i_start_addr;
            r_en       <= i_end_addr;
            r_ns       <= i_start_addr;
            r_nend     <= i_end_addr;
            r_data     <= i_write_data;
            r_addr     <= i_address;
            r_wi       <= i_start_addr;
            r_idx      <= '0;
            r_nk       <= '0;
            r_np       <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + CW'(1);
                if (!contained) begin
                    if (e.is_erase) begin
                        if (r_is_erase && !disjoint && !too_wide) begin
                            r_ns   <= us;
                            r_nend <= ue;
                        end else begin
                            r_tmp[r_nk[IW-1:0]] <= e;
                            r_nk <= r_nk + CW'(1);
                            if (r_is_erase && !disjoint) begin
                                if (e.end_addr > r_nend) begin
                                    r_nend <= e.start_addr;
                                end
                                if (e.start_addr < r_ns) begin
                                    r_ns <= e.end_addr;
                                end
                            end
                        end
                    end else begin
                        r_pgm[r_np[IW-1:0]] <= e;
                        r_np <= r_np + CW'(1);
                    end
                end
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end
            if (i_cmd.commit_step || i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.append && (r_cnt >= CW'(BUFFER_DEPTH))) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.word_step) begin
                r_wi <= r_wi + 8'd1;
            end
        end
    end

    // command list
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_step) begin
            r_list[r_idx[IW-1:0]] <= commit_e;
        end else if (i_cmd.append && (r_cnt < CW'(BUFFER_DEPTH))) begin
            r_list[r_cnt[IW-1:0]] <= '{is_erase: r_is_erase, start_addr: r_s,
                                       end_addr: r_en, data: r_data};
        end
    end

    // word memory
    assign mem_we    = i_cmd.word_step || (i_cmd.set_word && set_ok);
    assign mem_waddr = i_cmd.word_step ? AW'(r_wi) : AW'(r_addr);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_data;
        end
        if (i_cmd.lookup_rd) begin
            r_rdata <= r_mem[AW'(r_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_rhit    <= 1'b0;
        end else begin
            if (mem_we) begin
                r_present[mem_waddr] <= 1'b1;
            end
            if (i_cmd.lookup_rd) begin
                r_rhit <= set_ok && r_present[AW'(r_addr)];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_hit            <= 1'b0;
            o_read_data      <= '0;
            o_entry_valid    <= 1'b0;
            o_entry_is_erase <= 1'b0;
            o_entry_start    <= '0;
            o_entry_end      <= '0;
            o_entry_data     <= '0;
            o_entry_count    <= 5'(r_cnt);
            o_overflow       <= 1'b0;
            o_last           <= 1'b1;
            case (i_cmd.out_sel)
                wbec_pkg::OUT_LOOKUP: begin
                    o_hit       <= r_rhit;
                    o_read_data <= r_rhit ? r_rdata : '0;
                end
                wbec_pkg::OUT_DUMP: begin
                    o_entry_valid    <= 1'b1;
                    o_entry_is_erase <= e.is_erase;
                    o_entry_start    <= e.start_addr;
                    o_entry_end      <= e.end_addr;
                    o_entry_data     <= e.data;
                    o_last           <= o_sts.dump_last;
                end
                default: begin
                    o_overflow <= r_ovf;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/write_buffer_erase_coalescer_top.sv
// top level of the write buffer erase coalescer
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  request   | i_in_valid / o_in_ready    | kind, is_erase, start/end, data, address
//  result    | o_out_valid / i_out_ready  | hit, read_data, entry_*, count, overflow, last
//  config    | i_max_merge_span_we        | i_max_merge_span
//
//  an insert scans the list, rebuilds it and writes words before its status result;
//  a refused insert skips rebuild and words; lookup, append, set word and unknown kind
//  give one result; a dump gives one result per entry, up to 16, an empty dump a status result
//  reset is synchronous, active low; clears present bits and list count, merge limit to 10
//  ready only while idle, so a stalled result holds every later request off
`default_nettype none

module write_buffer_erase_coalescer_top #(
    parameter int ADDRESS_COUNT = 128,
    parameter int BUFFER_DEPTH  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_max_merge_span_we,
    input  wire logic [7:0]  i_max_merge_span,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic        i_is_erase,
    input  wire logic [7:0]  i_start_addr,
    input  wire logic [7:0]  i_end_addr,
    input  wire logic [31:0] i_write_data,
    input  wire logic [6:0]  i_address,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_hit,
    output logic [31:0]      o_read_data,
    output logic             o_entry_valid,
    output logic             o_entry_is_erase,
    output logic [7:0]       o_entry_start,
    output logic [7:0]       o_entry_end,
    output logic [31:0]      o_entry_data,
    output logic [4:0]       o_entry_count,
    output logic             o_overflow,
    output logic             o_last
);

    wbec_pkg::t_cmd cmd;
    wbec_pkg::t_sts sts;

    wbec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wbec_dp #(
        .ADDRESS_COUNT (ADDRESS_COUNT),
        .BUFFER_DEPTH  (BUFFER_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_max_merge_span_we (i_max_merge_span_we),
        .i_max_merge_span    (i_max_merge_span),
        .i_is_erase          (i_is_erase),
        .i_start_addr        (i_start_addr),
        .i_end_addr          (i_end_addr),
        .i_write_data        (i_write_data),
        .i_address           (i_address),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_hit               (o_hit),
        .o_read_data         (o_read_data),
        .o_entry_valid       (o_entry_valid),
        .o_entry_is_erase    (o_entry_is_erase),
        .o_entry_start       (o_entry_start),
        .o_entry_end         (o_entry_end),
        .o_entry_data        (o_entry_data),
        .o_entry_count       (o_entry_count),
        .o_overflow          (o_overflow),
        .o_last              (o_last)
    );

endmodule

`default_nettype wire

FILE: design/wbec_chk.sv
// port checker of the write buffer erase coalescer and its bind
`default_nettype none
`include "write_buffer_erase_coalescer_top_assert.svh"

module wbec_chk #(
    parameter int BUFFER_DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_hit,
    input wire logic [31:0] o_read_data,
    input wire logic        o_entry_valid,
    input wire logic [4:0]  o_entry_count,
    input wire logic        o_overflow
);

    `WBEC_ASSERT_HS(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)
    `WBEC_ASSERT(a_no_overlap, !(o_in_ready && o_out_valid), "request taken with result pending")
    `WBEC_ASSERT(a_count_max, o_out_valid |-> (int'(o_entry_count) <= BUFFER_DEPTH), "count over depth")
    `WBEC_ASSERT(a_miss_zero, o_out_valid && !o_hit |-> (o_read_data == 32'd0), "miss with data")
    `WBEC_ASSERT(a_excl, o_out_valid |-> !(o_overflow && (o_hit || o_entry_valid)), "mixed result")

endmodule

bind write_buffer_erase_coalescer_top wbec_chk #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_wbec_chk (.*);

`default_nettype wire
